// ===== hdl/plc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg
// Shared constants and types of the piecewise linear load curve.
// ----------------------------------------------------------------------------
package plc_pkg;

	localparam int MAX_POINTS = 16;
	localparam int PIDX_W     = $clog2(MAX_POINTS);
	localparam int COUNT_W    = 5;
	localparam int DATA_W     = 32;
	localparam int REGION_W   = 2;

	localparam logic [REGION_W-1:0] REGION_RAMP   = 2'd0;
	localparam logic [REGION_W-1:0] REGION_INSIDE = 2'd1;
	localparam logic [REGION_W-1:0] REGION_BEYOND = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	typedef struct packed {
		logic                     start;
		logic [2*DATA_W-1:0]      dividend;
		logic [DATA_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_stat_t;

endpackage

// ===== hdl/plc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_in_if / plc_out_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface plc_in_if import plc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [PIDX_W-1:0]        point_index;
	logic [DATA_W-1:0]        sample_time;
	logic signed [DATA_W-1:0] point_value;

	modport source (output valid, op, point_index, sample_time, point_value, input ready);
	modport sink   (input valid, op, point_index, sample_time, point_value, output ready);
endinterface

interface plc_out_if import plc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] load_value;
	logic [REGION_W-1:0]      region;

	modport source (output valid, load_value, region, input ready);
	modport sink   (input valid, load_value, region, output ready);
endinterface

// ===== hdl/plc_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_store
// Breakpoint memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module plc_store import plc_pkg::*; (
	input  logic                     clk,
	input  logic                     we,
	input  logic [PIDX_W-1:0]        waddr,
	input  logic [DATA_W-1:0]        wtime,
	input  logic [DATA_W-1:0]        wvalue,
	input  logic [PIDX_W-1:0]        raddr,
	output logic [DATA_W-1:0]        rtime,
	output logic [DATA_W-1:0]        rvalue
);

	logic [DATA_W-1:0] time_mem  [MAX_POINTS];
	logic [DATA_W-1:0] value_mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			time_mem[waddr]  <= wtime;
			value_mem[waddr] <= wvalue;
		end
	end

	always_ff @(posedge clk) begin
		rtime  <= time_mem[raddr];
		rvalue <= value_mem[raddr];
	end

endmodule

// ===== hdl/plc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_div
// Unsigned restoring divider, 64 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plc_div import plc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output div_stat_t stat
);

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rh_q;
	logic [DATA_W-1:0] rl_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;
	logic              ge;

	assign shifted = {rh_q, rl_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rh_q  <= req.dividend[2*DATA_W-1:DATA_W];
			rl_q  <= req.dividend[DATA_W-1:0];
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rh_q <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			rl_q <= {rl_q[DATA_W-2:0], ge};
		end
	end

	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign stat.quotient = rl_q;

endmodule

// ===== hdl/piecewise_linear_load_curve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_load_curve
// Write item: accepted every cycle while idle, no result. Evaluate item: result
// computed by the segment search (one breakpoint per cycle from the memory port,
// up to 15 breakpoints), one multiply-accumulate pass in the ramp or two inside
// a segment, and the bit-serial divide; one item at a time, the next accepted in
// the cycle after the result loads. The result register lets it in while a result waits.
// arst_n clears control state and point_count; breakpoints are undefined.
// ----------------------------------------------------------------------------
module piecewise_linear_load_curve import plc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	plc_in_if.sink             in_ch,
	plc_out_if.source          out_ch
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_FIRST  = 8'b0000_0010,
		S_SEARCH = 8'b0000_0100,
		S_MUL    = 8'b0000_1000,
		S_ACC    = 8'b0001_0000,
		S_DSTART = 8'b0010_0000,
		S_DIV    = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t                   state_q;
	logic [COUNT_W-1:0]       count_q;
	logic [COUNT_W-1:0]       n_q;
	logic [PIDX_W-1:0]        idx_q;
	logic [DATA_W-1:0]        t_q;
	logic [DATA_W-1:0]        ta_q;
	logic [DATA_W-1:0]        va_q;
	logic signed [DATA_W-1:0] ma_q;
	logic [DATA_W-1:0]        mb_q;
	logic signed [DATA_W-1:0] ma2_q;
	logic [DATA_W-1:0]        mb2_q;
	logic                     second_q;
	logic [2*DATA_W-1:0]      prod_q;
	logic [2*DATA_W-1:0]      acc_q;
	logic [DATA_W-1:0]        dvs_q;
	logic                     neg_q;
	logic [DATA_W-1:0]        res_load_q;
	logic [REGION_W-1:0]      res_region_q;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        out_load_q;
	logic [REGION_W-1:0]      out_region_q;

	logic                     in_acc;
	logic [PIDX_W-1:0]        raddr;
	logic [DATA_W-1:0]        rd_time;
	logic [DATA_W-1:0]        rd_value;
	logic signed [2*DATA_W:0] mul_full;
	logic [2*DATA_W-1:0]      acc_abs;
	logic                     seg_hit;
	logic                     last_seg;
	logic                     out_load;
	div_req_t                 dreq;
	div_stat_t                dstat;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);

	assign seg_hit  = (t_q > ta_q) && (t_q <= rd_time);
	assign last_seg = ({1'b0, idx_q} + COUNT_W'(1)) == n_q;
	assign mul_full = ma_q * $signed({1'b0, mb_q});
	assign acc_abs  = acc_q[2*DATA_W-1] ? (~acc_q + 1'b1) : acc_q;

	always_comb begin
		case (state_q)
			S_FIRST:  raddr = PIDX_W'(1);
			S_SEARCH: raddr = idx_q + 1'b1;
			default:  raddr = '0;
		endcase
	end

	plc_store u_store (
		.clk    (clk),
		.we     (in_acc && in_ch.op == OP_WRITE),
		.waddr  (in_ch.point_index),
		.wtime  (in_ch.sample_time),
		.wvalue (in_ch.point_value),
		.raddr  (raddr),
		.rtime  (rd_time),
		.rvalue (rd_value)
	);

	assign dreq.start    = (state_q == S_DSTART);
	assign dreq.dividend = acc_abs;
	assign dreq.divisor  = dvs_q;

	plc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.stat   (dstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && in_ch.op == OP_EVAL) begin
						state_q <= (count_q == '0) ? S_DONE : S_FIRST;
					end
				end
				S_FIRST: begin
					if (t_q <= rd_time) begin
						state_q <= (rd_time == '0) ? S_DONE : S_MUL;
					end else begin
						state_q <= (n_q == COUNT_W'(1)) ? S_DONE : S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (seg_hit) begin
						state_q <= S_MUL;
					end else if (last_seg) begin
						state_q <= S_DONE;
					end
				end
				S_MUL:    state_q <= S_ACC;
				S_ACC:    state_q <= second_q ? S_MUL : S_DSTART;
				S_DSTART: state_q <= S_DIV;
				S_DIV: begin
					if (dstat.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				t_q          <= in_ch.sample_time;
				n_q          <= (count_q > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : count_q;
				idx_q        <= '0;
				res_load_q   <= '0;
				res_region_q <= REGION_BEYOND;
			end
			S_FIRST: begin
				acc_q <= '0;
				if (t_q <= rd_time) begin
					res_region_q <= REGION_RAMP;
					ma_q         <= $signed(rd_value);
					mb_q         <= t_q;
					second_q     <= 1'b0;
					dvs_q        <= rd_time;
				end else begin
					ta_q  <= rd_time;
					va_q  <= rd_value;
					idx_q <= PIDX_W'(1);
				end
			end
			S_SEARCH: begin
				if (seg_hit) begin
					res_region_q <= REGION_INSIDE;
					ma_q         <= $signed(va_q);
					mb_q         <= rd_time - t_q;
					ma2_q        <= $signed(rd_value);
					mb2_q        <= t_q - ta_q;
					second_q     <= 1'b1;
					dvs_q        <= rd_time - ta_q;
				end else begin
					ta_q  <= rd_time;
					va_q  <= rd_value;
					idx_q <= idx_q + 1'b1;
				end
			end
			S_MUL: begin
				prod_q <= mul_full[2*DATA_W-1:0];
			end
			S_ACC: begin
				acc_q    <= acc_q + prod_q;
				ma_q     <= ma2_q;
				mb_q     <= mb2_q;
				second_q <= 1'b0;
			end
			S_DSTART: begin
				neg_q <= acc_q[2*DATA_W-1];
			end
			S_DIV: begin
				if (dstat.done) begin
					res_load_q <= neg_q ? (~dstat.quotient + 1'b1) : dstat.quotient;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_load_q   <= res_load_q;
			out_region_q <= res_region_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.load_value = $signed(out_load_q);
	assign out_ch.region     = out_region_q;

	property p_ready_div_idle;
		@(posedge clk) disable iff (!arst_n) in_ch.ready |-> !dstat.busy;
	endproperty
	a_ready_div_idle: assert property (p_ready_div_idle)
		else $error("input ready while divider busy");

	property p_done_in_div;
		@(posedge clk) disable iff (!arst_n) dstat.done |-> (state_q == S_DIV);
	endproperty
	a_done_in_div: assert property (p_done_in_div)
		else $error("divider done outside divide state");

	property p_beyond_zero;
		@(posedge clk) disable iff (!arst_n)
			(out_ch.valid && out_ch.region == REGION_BEYOND) |-> (out_ch.load_value == '0);
	endproperty
	a_beyond_zero: assert property (p_beyond_zero)
		else $error("nonzero load beyond table");

	property p_search_bound;
		@(posedge clk) disable iff (!arst_n)
			(state_q == S_SEARCH) |-> ({1'b0, idx_q} < n_q);
	endproperty
	a_search_bound: assert property (p_search_bound)
		else $error("segment search past point count");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the piecewise linear load curve. A directed table covers the
// empty table, a first breakpoint at time zero, the ramp, the edges of the
// time and load ranges, breakpoints out of order and point counts of 0 to 3.
// Random rounds then load ascending curves at several time scales, set point
// counts up to the field maximum and query inside segments, on breakpoints, in
// the ramp and beyond the end, with stray writes mixed in. Every result is
// compared with its row's pinned value or a local predictor of the interpolation,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb import plc_pkg::*; ();

	localparam int CLK_HALF       = 6;
	localparam int RANDOM_ITEMS   = 1200;
	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DIRECTED_ROWS  = 27;

	typedef struct packed {
		logic signed [DATA_W-1:0] load;
		logic [REGION_W-1:0]      region;
	} load_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [COUNT_W-1:0] count;
		logic               op;
		logic [PIDX_W-1:0]  idx;
		logic [DATA_W-1:0]  t;
		logic [DATA_W-1:0]  v;
		logic               pinned;
		load_result_t       expected;
	} stim_row_t;

	typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_SPARSE} sink_mode_t;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_CFG,  5'd0, OP_WRITE, 4'd0, 32'h0000_0000, 32'h0, 1'b0, '{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'h0000_0000, 32'h0, 1'b1, '{32'h0, REGION_BEYOND}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'hFFFF_FFFF, 32'h0, 1'b1, '{32'h0, REGION_BEYOND}},
		'{ROW_ITEM, 5'd0, OP_WRITE, 4'd0, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0,
			'{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_WRITE, 4'd1, 32'h0001_0000, 32'h8000_0000, 1'b0,
			'{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_WRITE, 4'd2, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0,
			'{32'h0, REGION_RAMP}},
		'{ROW_CFG,  5'd3, OP_WRITE, 4'd0, 32'h0000_0000, 32'h0, 1'b0, '{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'h0000_0000, 32'h0, 1'b1, '{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'h0000_8000, 32'h0, 1'b0, '{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'h0001_0000, 32'h0, 1'b1,
			'{32'h8000_0000, REGION_INSIDE}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'hFFFF_FFFF, 32'h0, 1'b1,
			'{32'h7FFF_FFFF, REGION_INSIDE}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'h0001_0001, 32'h0, 1'b0, '{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_WRITE, 4'd0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0,
			'{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'hFFFF_FFFF, 32'h0, 1'b1,
			'{32'h8000_0000, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'h0000_0001, 32'h0, 1'b0, '{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'h0000_0000, 32'h0, 1'b1, '{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_WRITE, 4'd0, 32'h0001_0000, 32'h0002_0000, 1'b0,
			'{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_WRITE, 4'd1, 32'h0000_8000, 32'hFFFF_0000, 1'b0,
			'{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_WRITE, 4'd2, 32'h0003_0000, 32'h7FFF_FFFF, 1'b0,
			'{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'h0000_C000, 32'h0, 1'b0, '{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'h0002_0000, 32'h0, 1'b0, '{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'h0003_0001, 32'h0, 1'b1, '{32'h0, REGION_BEYOND}},
		'{ROW_CFG,  5'd2, OP_WRITE, 4'd0, 32'h0000_0000, 32'h0, 1'b0, '{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'h0002_0000, 32'h0, 1'b1, '{32'h0, REGION_BEYOND}},
		'{ROW_CFG,  5'd1, OP_WRITE, 4'd0, 32'h0000_0000, 32'h0, 1'b0, '{32'h0, REGION_RAMP}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'h0001_0001, 32'h0, 1'b1, '{32'h0, REGION_BEYOND}},
		'{ROW_ITEM, 5'd0, OP_EVAL,  4'd0, 32'h0001_0000, 32'h0, 1'b1,
			'{32'h0002_0000, REGION_RAMP}}
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;

	plc_in_if  in_ch ();
	plc_out_if out_ch ();

	piecewise_linear_load_curve dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// predictor state, updated at each accepted write item
	logic [DATA_W-1:0]        curve_time [MAX_POINTS];
	logic signed [DATA_W-1:0] curve_load [MAX_POINTS];
	logic [COUNT_W-1:0]       curve_count;

	// breakpoint times as planned by the stimulus
	logic [DATA_W-1:0] plan_time [MAX_POINTS];

	load_result_t expected_loads [$];
	logic         pin_valid;
	load_result_t pin_result;

	int         mismatch_count;
	int         quiet_cycles;
	int         burst_left;
	int         sink_left;
	sink_mode_t sink_mode;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic load_result_t predict_load(input logic [DATA_W-1:0] t);
		load_result_t res;
		int           n;
		longint       tq;
		longint       ta;
		longint       tb_end;
		longint       va;
		longint       vb;
		res.load   = '0;
		res.region = REGION_BEYOND;
		n = (curve_count > MAX_POINTS) ? MAX_POINTS : int'(curve_count);
		tq = t;
		if (n == 0)
			return res;
		if (t <= curve_time[0]) begin
			res.region = REGION_RAMP;
			ta = curve_time[0];
			va = curve_load[0];
			if (ta != 0)
				res.load = DATA_W'(va * tq / ta);
			return res;
		end
		for (int i = 0; i + 1 < n; i++) begin
			ta     = curve_time[i];
			tb_end = curve_time[i+1];
			if (tq > ta && tq <= tb_end) begin
				va = curve_load[i];
				vb = curve_load[i+1];
				res.load   = DATA_W'((va * (tb_end - tq) + vb * (tq - ta)) / (tb_end - ta));
				res.region = REGION_INSIDE;
				return res;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 40)
			$display("mismatch at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// sender in bursts: a new burst may open with a gap
	task automatic send_item(input logic op, input logic [PIDX_W-1:0] idx,
			input logic [DATA_W-1:0] t, input logic [DATA_W-1:0] v,
			input logic pinned, input load_result_t pin);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_ch.valid       <= 1'b1;
		in_ch.op          <= op;
		in_ch.point_index <= idx;
		in_ch.sample_time <= t;
		in_ch.point_value <= v;
		pin_valid         <= pinned;
		pin_result        <= pin;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_loads.size() != 0)
			@(posedge clk);
	endtask

	// writes leave no result, so give the block time to go idle
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [COUNT_W-1:0] count);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= count;
		@(negedge clk);
		cfg_we <= 1'b0;
		curve_count = count;
	endtask

	function automatic logic [DATA_W-1:0] pick_load();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
			default: return $urandom();
		endcase
	endfunction

	// ascending curve over all slots at a random time scale
	task automatic load_curve();
		longint unsigned acc;
		int unsigned     step_max;
		case ($urandom_range(0, 3))
			0: step_max = 1;
			1: step_max = 300;
			2: step_max = 32'h0001_0000;
			default: step_max = 32'h0800_0000;
		endcase
		acc = ($urandom_range(0, 3) == 0) ? 0 : ($urandom() >> $urandom_range(0, 31));
		for (int s = 0; s < MAX_POINTS; s++) begin
			if (s > 0)
				acc += $urandom_range(0, step_max);
			if (acc > 64'hFFFF_FFFF)
				acc = 64'hFFFF_FFFF;
			plan_time[s] = acc[DATA_W-1:0];
			send_item(OP_WRITE, PIDX_W'(s), acc[DATA_W-1:0], pick_load(), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			if (in_ch.op == OP_WRITE) begin
				curve_time[in_ch.point_index] = in_ch.sample_time;
				curve_load[in_ch.point_index] = in_ch.point_value;
			end else if (pin_valid) begin
				expected_loads.push_back(pin_result);
			end else begin
				expected_loads.push_back(predict_load(in_ch.sample_time));
			end
		end
	end

	always @(posedge clk) begin
		load_result_t exp_res;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_loads.size() == 0) begin
				report_mismatch($sformatf("result with no item pending: load %h region %0d",
					out_ch.load_value, out_ch.region));
			end else begin
				exp_res = expected_loads.pop_front();
				if (out_ch.load_value !== exp_res.load)
					report_mismatch($sformatf("load_value %h, expected %h",
						out_ch.load_value, exp_res.load));
				if (out_ch.region !== exp_res.region)
					report_mismatch($sformatf("region %0d, expected %0d",
						out_ch.region, exp_res.region));
			end
		end
	end

	// result side stalls on its own pattern
	always @(negedge clk) begin
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 2));
			sink_left = $urandom_range(20, 300);
		end
		sink_left--;
		case (sink_mode)
			SINK_OPEN:   out_ch.ready <= 1'b1;
			SINK_CHOPPY: out_ch.ready <= 1'($urandom_range(0, 1));
			default:     out_ch.ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles with no item moving", WATCHDOG_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		int                round_no;
		int                random_items;
		int                burst_len;
		int                seg;
		int                n;
		logic [COUNT_W-1:0] count;
		logic [DATA_W-1:0] t;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		in_ch.valid       = 1'b0;
		in_ch.op          = OP_WRITE;
		in_ch.point_index = '0;
		in_ch.sample_time = '0;
		in_ch.point_value = '0;
		out_ch.ready      = 1'b0;
		pin_valid         = 1'b0;
		pin_result        = '0;
		curve_count       = '0;
		mismatch_count    = 0;
		quiet_cycles      = 0;
		burst_left        = 0;
		sink_left         = 0;
		sink_mode         = SINK_OPEN;
		for (int s = 0; s < MAX_POINTS; s++) begin
			curve_time[s] = '0;
			curve_load[s] = '0;
			plan_time[s]  = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < DIRECTED_ROWS; k++) begin
			if (DIRECTED[k].kind == ROW_CFG) begin
				settle();
				write_count(DIRECTED[k].count);
			end else begin
				send_item(DIRECTED[k].op, DIRECTED[k].idx, DIRECTED[k].t, DIRECTED[k].v,
					DIRECTED[k].pinned, DIRECTED[k].expected);
			end
		end

		round_no     = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			settle();
			case (round_no)
				0: count = 5'd16;
				1: count = 5'd31;
				2: count = 5'd0;
				3: count = 5'd1;
				default: begin
					case ($urandom_range(0, 7))
						0: count = COUNT_W'($urandom_range(17, 31));
						1: count = 5'd0;
						default: count = COUNT_W'($urandom_range(1, 16));
					endcase
				end
			endcase
			write_count(count);
			n = (count > MAX_POINTS) ? MAX_POINTS : int'(count);
			load_curve();
			random_items += MAX_POINTS;
			burst_len = $urandom_range(30, 60);
			for (int j = 0; j < burst_len; j++) begin
				if (j == burst_len / 2 && (round_no == 0 || $urandom_range(0, 2) == 0))
					drain();
				if ($urandom_range(0, 6) == 0) begin
					// stray write, may break the ordering of times
					seg = $urandom_range(0, MAX_POINTS - 1);
					t   = $urandom();
					plan_time[seg] = t;
					send_item(OP_WRITE, PIDX_W'(seg), t, pick_load(), 1'b0, '0);
				end else begin
					case ($urandom_range(0, 9))
						0: t = '0;
						1: t = 32'hFFFF_FFFF;
						2: t = $urandom();
						3, 4: t = plan_time[$urandom_range(0, MAX_POINTS - 1)];
						5: t = plan_time[$urandom_range(0, MAX_POINTS - 1)] + 1;
						6: t = $urandom_range(0, plan_time[0]);
						default: begin
							seg = (n > 1) ? $urandom_range(0, n - 2) : 0;
							lo  = plan_time[seg];
							hi  = plan_time[seg+1];
							if (hi > lo)
								t = lo + $urandom_range(1, hi - lo);
							else
								t = $urandom();
						end
					endcase
					send_item(OP_EVAL, PIDX_W'($urandom_range(0, MAX_POINTS - 1)), t, $urandom(),
						1'b0, '0);
				end
				random_items++;
			end
			round_no++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_loads.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_loads.size()));
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/plc_pkg.sv
hdl/plc_if.sv
hdl/plc_store.sv
hdl/plc_div.sv
hdl/piecewise_linear_load_curve.sv
dv/tb.sv
